[src/hdlc_tx_pkg.sv]
// Shared types and constants of the HDLC transmit framer.
// Used by hdlc_tx_ctrl, hdlc_tx_dp and hdlc_frame_transmitter; no dependencies.
package hdlc_tx_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned OnesW   = 3;
  localparam logic [7:0]  Flag    = 8'h7E;
  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef enum logic [1:0] {
    SEL_FLAG,
    SEL_DATA,
    SEL_FCS,
    SEL_ZERO
  } bit_sel_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    bit_sel_t sel;
    logic     run_end;
    logic     step_cnt;
    logic     clr_cnt;
    logic     frame_end;
  } dp_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic last;
    logic data_bit;
    logic fcs_bit;
    logic ones_is4;
    logic cnt_is7;
    logic cnt_is15;
  } dp_stat_t;

endpackage

[src/hdlc_frame_transmitter.sv]
// Top level of the HDLC transmit framer with bit stuffing and CRC-16/X.25.
// Depends on hdlc_tx_pkg, hdlc_tx_ctrl and hdlc_tx_dp.

// Each accepted byte is sent least significant bit first, one line bit per
// output beat; the first byte of a frame is preceded by the 0x7E flag, and a
// byte with tlast set is followed by the complemented FCS and the closing flag.
// A zero is stuffed after five ones of payload or FCS. out_tlast marks the
// last line bit caused by an input byte. The serializer sends at most one line
// bit per clock while the sink is ready, so a byte inside a frame is taken in
// S_IDLE and then sends 8 data bits and up to 2 stuffed zeros; an opening
// byte adds the 8 flag bits and a closing byte adds 16 FCS bits, up to 4
// stuffed zeros and the 8 flag bits. A new byte is taken only
// after the previous byte's bits have all been loaded into the output register.
module hdlc_frame_transmitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] line_bit, [7:1] zero
  output logic       out_tlast   // run_end
);
  import hdlc_tx_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     line_bit;

  hdlc_tx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  hdlc_tx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .line_bit  (line_bit),
    .run_end   (out_tlast)
  );

  assign out_tdata = {7'b0, line_bit};

endmodule

[src/hdlc_tx_dp.sv]
// Datapath of the HDLC transmit framer: byte register, CRC-16/X.25, ones run,
// bit counter and the output payload register. Depends on hdlc_tx_pkg.
module hdlc_tx_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hdlc_tx_pkg::dp_cmd_t          cmd,
  output hdlc_tx_pkg::dp_stat_t         stat,
  input  logic [hdlc_tx_pkg::DataW-1:0] data_byte,
  input  logic                          last_byte,
  output logic                          line_bit,
  output logic                          run_end
);
  import hdlc_tx_pkg::*;

  logic [DataW-1:0] byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [OnesW-1:0] ones_r, ones_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             bit_r, bit_nxt;
  logic             end_r, end_nxt;
  logic             cur_bit;

  always_comb begin
    case (cmd.sel)
      SEL_FLAG: cur_bit = Flag[cnt_r[2:0]];
      SEL_DATA: cur_bit = byte_r[0];
      SEL_FCS:  cur_bit = ~crc_r[0];
      default:  cur_bit = 1'b0;
    endcase
  end

  always_comb begin
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    crc_nxt      = crc_r;
    ones_nxt     = ones_r;
    cnt_nxt      = cnt_r;
    in_frame_nxt = in_frame_r;
    bit_nxt      = bit_r;
    end_nxt      = end_r;
    if (cmd.load) begin
      byte_nxt     = data_byte;
      last_nxt     = last_byte;
      in_frame_nxt = 1'b1;
    end
    if (cmd.emit) begin
      bit_nxt = cur_bit;
      end_nxt = cmd.run_end;
      case (cmd.sel)
        SEL_DATA: begin
          byte_nxt = {1'b0, byte_r[DataW-1:1]};
          if (byte_r[0] ^ crc_r[0]) begin
            crc_nxt = {1'b0, crc_r[15:1]} ^ CrcPoly;
          end else begin
            crc_nxt = {1'b0, crc_r[15:1]};
          end
          ones_nxt = cur_bit ? ones_r + 1'b1 : '0;
        end
        SEL_FCS: begin
          // Shifting in ones leaves the preset value once the FCS is out.
          crc_nxt  = {1'b1, crc_r[15:1]};
          ones_nxt = cur_bit ? ones_r + 1'b1 : '0;
        end
        SEL_ZERO: ones_nxt = '0;
        default:  ones_nxt = ones_r;
      endcase
    end
    if (cmd.clr_cnt) begin
      cnt_nxt = '0;
    end else if (cmd.step_cnt) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.frame_end) begin
      crc_nxt      = CrcInit;
      ones_nxt     = '0;
      in_frame_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    bit_r  <= bit_nxt;
    end_r  <= end_nxt;
    if (!rst_n) begin
      crc_r      <= CrcInit;
      ones_r     <= '0;
      cnt_r      <= '0;
      in_frame_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      ones_r     <= ones_nxt;
      cnt_r      <= cnt_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  assign stat.in_frame = in_frame_r;
  assign stat.last     = last_r;
  assign stat.data_bit = byte_r[0];
  assign stat.fcs_bit  = ~crc_r[0];
  assign stat.ones_is4 = (ones_r == OnesW'(4));
  assign stat.cnt_is7  = (cnt_r[2:0] == 3'd7);
  assign stat.cnt_is15 = (cnt_r[3:0] == 4'd15);

  assign line_bit = bit_r;
  assign run_end  = end_r;

endmodule

[src/hdlc_tx_ctrl.sv]
// Controller of the HDLC transmit framer: sequences flag, data, stuffed zero
// and FCS bits and owns the output valid flag. Depends on hdlc_tx_pkg.
module hdlc_tx_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hdlc_tx_pkg::dp_cmd_t  cmd,
  input  hdlc_tx_pkg::dp_stat_t stat
);
  import hdlc_tx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_DATA,
    S_FCS,
    S_STUFF,
    S_CLOSE
  } state_t;

  state_t state_r, state_nxt;
  logic   from_fcs_r, from_fcs_nxt;
  logic   final_r, final_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   emit_ok;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    from_fcs_nxt = from_fcs_r;
    final_nxt    = final_r;
    cmd          = '0;
    cmd.sel      = SEL_FLAG;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.clr_cnt = 1'b1;
          state_nxt   = stat.in_frame ? S_DATA : S_OPEN;
        end
      end
      S_OPEN: begin
        if (emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_FLAG;
          cmd.step_cnt = 1'b1;
          if (stat.cnt_is7) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_DATA;
          cmd.step_cnt = 1'b1;
          cmd.clr_cnt  = stat.cnt_is7;
          if (stat.data_bit && stat.ones_is4) begin
            from_fcs_nxt = 1'b0;
            final_nxt    = stat.cnt_is7;
            state_nxt    = S_STUFF;
          end else if (stat.cnt_is7) begin
            if (stat.last) begin
              state_nxt = S_FCS;
            end else begin
              cmd.run_end = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
        end
      end
      S_FCS: begin
        if (emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_FCS;
          cmd.step_cnt = 1'b1;
          cmd.clr_cnt  = stat.cnt_is15;
          if (stat.fcs_bit && stat.ones_is4) begin
            from_fcs_nxt = 1'b1;
            final_nxt    = stat.cnt_is15;
            state_nxt    = S_STUFF;
          end else if (stat.cnt_is15) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_STUFF: begin
        if (emit_ok) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_ZERO;
          if (from_fcs_r) begin
            state_nxt = final_r ? S_CLOSE : S_FCS;
          end else if (!final_r) begin
            state_nxt = S_DATA;
          end else if (stat.last) begin
            state_nxt = S_FCS;
          end else begin
            cmd.run_end = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_FLAG;
          cmd.step_cnt = 1'b1;
          if (stat.cnt_is7) begin
            cmd.run_end   = 1'b1;
            cmd.frame_end = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      from_fcs_r  <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_fcs_r  <= from_fcs_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
